// ===== rtl/core/urbb_pkg.sv =====
// ----------------------------------------------------------------------------
// urbb_pkg
// Shared constants and helpers of the bounded uniform random engine.
// ----------------------------------------------------------------------------
package urbb_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int DIV_W       = 32;

  // well1024a tap offsets
  localparam int WELL_M1 = 3;
  localparam int WELL_M2 = 24;
  localparam int WELL_M3 = 10;

  localparam logic [31:0] LCG_MUL   = 32'd1103515245;
  localparam logic [31:0] LCG_ADD   = 32'd12345;
  localparam logic [28:0] BOUND_MAX = 29'h1000_0000;
  localparam logic [16:0] FIX_MUL   = 17'd1000;
  localparam logic [31:0] FIX_DIV   = 32'd100000;
  // ceil(2^39 / 3125), exact for dividends below 2^27
  localparam logic [27:0] FIX_RECIP = 28'd175921861;

  localparam logic [1:0] FUNC_SEED = 2'd0;
  localparam logic [1:0] FUNC_LOAD = 2'd1;
  localparam logic [1:0] FUNC_DRAW = 2'd2;

  localparam logic [1:0] CFG_USE_LCG   = 2'd0;
  localparam logic [1:0] CFG_FIXED_EN  = 2'd1;
  localparam logic [1:0] CFG_FIXED_PCT = 2'd2;

  function automatic logic [31:0] lcg_next(input logic [31:0] x);
    lcg_next = x * LCG_MUL + LCG_ADD;
  endfunction

endpackage

// ===== rtl/core/urbb_div.sv =====
// ----------------------------------------------------------------------------
// urbb_div
// Restoring divider, one quotient bit per cycle, done pulse when finished.
// ----------------------------------------------------------------------------
module urbb_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [urbb_pkg::DIV_W-1:0]  dividend,
  input  logic [urbb_pkg::DIV_W-1:0]  divisor,
  output logic                        done,
  output logic [urbb_pkg::DIV_W-1:0]  quotient
);
  import urbb_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] den_r;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        den_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/uniform_random_below_bound_core.sv =====
// ----------------------------------------------------------------------------
// uniform_random_below_bound_core
// Random engine with an lcg and a well1024a table, drawing unbiased values
// below a bound by rejection sampling.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low. in_func picks
// the command: seed the table from in_seed, load the lcg with in_seed, or draw
// a value below in_range_m. Only a draw gives a result: out_valid is high for
// exactly one cycle with out_value; the receiver cannot stall it.
// A draw with a bound of one or less answers in the cycle after it is taken;
// a fixed-mode draw registers the product in S_FIX1 and does the division
// by 100000 as a reciprocal multiply in S_FIX2. A random draw first runs the
// partition division, then one attempt after another with the lcg or with
// the well table; each attempt is set by the shared divider and by the
// single read port of the table memory (five reads, two writes per step).
// The result follows in the cycle after the last attempt.
// Seeding keeps busy high through 32 table writes, the load of the first word
// and 320 add steps, one memory read per step. Load sets the lcg in idle.
// busy stays high while a request is in progress. Reset clears the table
// (valid bits), index, lcg and the registers (use_lcg = 1). The cfg port
// writes registers; keeping to idle is for the user, the block does not enforce it.
// ----------------------------------------------------------------------------
module uniform_random_below_bound_core #(
  parameter int TABLE_DEPTH = urbb_pkg::TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_seed,
  input  logic [28:0] in_range_m,
  output logic        out_valid,
  output logic [31:0] out_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);
  import urbb_pkg::*;

  localparam int IDX_W     = $clog2(TABLE_DEPTH);
  localparam int MIX_STEPS = TABLE_DEPTH * 10;
  localparam int CNT_W     = $clog2(MIX_STEPS);
  localparam logic [IDX_W-1:0] OFF_LAST = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_MIXLD, S_MIXLDW, S_MIXRD, S_MIXWR, S_FIX1, S_FIX2,
    S_GEN, S_WREAD, S_WWR0, S_WWR1, S_DIVW
  } state_t;

  typedef enum logic [1:0] {
    K_PART, K_DRAW
  } div_kind_t;

  state_t          state_r;
  div_kind_t       kind_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]     lcg_r;
  logic [31:0]     fill_w_r;
  logic [31:0]     carry_r;
  logic [28:0]     m_r;
  logic [27:0]     part_r;
  logic [16:0]     p1_r;
  logic [31:0]     fix_prod_r;
  logic [31:0]     v0_r, a1_r, a2_r, a3_r, t0_r, t1_r, t2_r;
  logic            div_go_r;
  logic [31:0]     div_a_r;
  logic [31:0]     div_b_r;
  logic            out_valid_r;
  logic [31:0]     out_value_r;
  logic            use_lcg_r;
  logic            fixed_en_r;
  logic [6:0]      fixed_pct_r;

  logic [31:0]      mem [TABLE_DEPTH];
  logic [31:0]      mem_q_r;
  logic             rvld_r;
  logic [TABLE_DEPTH-1:0] vld_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  logic [31:0]      mem_wdata;
  logic [31:0]      rdata;
  logic [IDX_W-1:0] rd_off;
  logic [31:0]      lcg_nxt;
  logic [31:0]      mix_sum;
  logic [31:0]      t1, t2, nv;
  logic [28:0]      m_sat;
  logic [54:0]      fix_q;
  logic             div_done;
  logic [31:0]      div_q;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_lcg_r   <= 1'b1;
      fixed_en_r  <= 1'b0;
      fixed_pct_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USE_LCG:   use_lcg_r   <= cfg_wdata[0];
        CFG_FIXED_EN:  fixed_en_r  <= cfg_wdata[0];
        CFG_FIXED_PCT: fixed_pct_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  assign rdata   = rvld_r ? mem_q_r : 32'd0;
  assign lcg_nxt = lcg_next((state_r == S_FILL) ? fill_w_r : lcg_r);
  assign mix_sum = rdata + carry_r;
  assign m_sat   = (in_range_m > BOUND_MAX) ? BOUND_MAX : in_range_m;

  // divide by 100000 as divide by 32, then by 3125 through the reciprocal
  assign fix_q = fix_prod_r[31:5] * FIX_RECIP;

  assign t1 = v0_r ^ a1_r ^ (a1_r >> 8);
  assign t2 = a2_r ^ (a2_r << 19) ^ a3_r ^ (a3_r << 14);
  assign nv = t0_r ^ (t0_r << 11) ^ t1_r ^ (t1_r << 7) ^ t2_r ^ (t2_r << 13);

  always_comb begin
    case (cnt_r[2:0])
      3'd0:    rd_off = '0;
      3'd1:    rd_off = IDX_W'(WELL_M1);
      3'd2:    rd_off = IDX_W'(WELL_M2);
      3'd3:    rd_off = IDX_W'(WELL_M3);
      default: rd_off = OFF_LAST;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = 32'd0;
    mem_raddr = idx_r;
    case (state_r)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[IDX_W-1:0];
        mem_wdata = fill_w_r;
      end
      S_MIXRD: mem_raddr = idx_r + 1'b1;
      S_MIXWR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r + 1'b1;
        mem_wdata = mix_sum;
      end
      S_WREAD: mem_raddr = idx_r + rd_off;
      S_WWR0: begin
        mem_we    = 1'b1;
        mem_wdata = t1 ^ t2;
      end
      S_WWR1: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r + OFF_LAST;
        mem_wdata = nv;
      end
      default: ;
    endcase
  end

  // table memory, synchronous read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[mem_raddr];
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
    end
  end

  urbb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= K_PART;
      cnt_r       <= '0;
      idx_r       <= '0;
      lcg_r       <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            case (in_func)
              FUNC_SEED: begin
                fill_w_r <= in_seed;
                cnt_r    <= '0;
                state_r  <= S_FILL;
              end
              FUNC_LOAD: lcg_r <= in_seed;
              FUNC_DRAW: begin
                m_r <= m_sat;
                if (m_sat <= 29'd1) begin
                  out_valid_r <= 1'b1;
                  out_value_r <= 32'd0;
                end else if (fixed_en_r) begin
                  p1_r    <= 17'(fixed_pct_r) * FIX_MUL;
                  state_r <= S_FIX1;
                end else begin
                  div_a_r  <= 32'(BOUND_MAX);
                  div_b_r  <= {3'b0, m_sat};
                  div_go_r <= 1'b1;
                  kind_r   <= K_PART;
                  state_r  <= S_DIVW;
                end
              end
              default: ;
            endcase
          end
        end
        S_FILL: begin
          fill_w_r <= lcg_nxt;
          if (cnt_r == CNT_W'(TABLE_DEPTH - 1)) begin
            state_r <= S_MIXLD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MIXLD: state_r <= S_MIXLDW;
        S_MIXLDW: begin
          carry_r <= rdata;
          cnt_r   <= '0;
          state_r <= S_MIXRD;
        end
        S_MIXRD: state_r <= S_MIXWR;
        S_MIXWR: begin
          carry_r <= mix_sum;
          idx_r   <= idx_r + 1'b1;
          if (cnt_r == CNT_W'(MIX_STEPS - 1)) begin
            state_r <= S_IDLE;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_MIXRD;
          end
        end
        S_FIX1: begin
          fix_prod_r <= 32'(p1_r) * 32'(m_r - 29'd1);
          state_r    <= S_FIX2;
        end
        S_FIX2: begin
          out_valid_r <= 1'b1;
          out_value_r <= {16'd0, fix_q[54:39]};
          state_r     <= S_IDLE;
        end
        S_GEN: begin
          if (use_lcg_r) begin
            lcg_r    <= lcg_nxt;
            div_a_r  <= {4'b0, lcg_nxt[31:4]};
            div_b_r  <= {4'b0, part_r};
            div_go_r <= 1'b1;
            kind_r   <= K_DRAW;
            state_r  <= S_DIVW;
          end else begin
            cnt_r   <= '0;
            state_r <= S_WREAD;
          end
        end
        S_WREAD: begin
          case (cnt_r[2:0])
            3'd1:    v0_r <= rdata;
            3'd2:    a1_r <= rdata;
            3'd3:    a2_r <= rdata;
            3'd4:    a3_r <= rdata;
            3'd5:    t0_r <= rdata;
            default: ;
          endcase
          if (cnt_r[2:0] == 3'd5) begin
            state_r <= S_WWR0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_WWR0: begin
          t1_r    <= t1;
          t2_r    <= t2;
          state_r <= S_WWR1;
        end
        S_WWR1: begin
          idx_r    <= idx_r + OFF_LAST;
          div_a_r  <= {4'b0, nv[31:4]};
          div_b_r  <= {4'b0, part_r};
          div_go_r <= 1'b1;
          kind_r   <= K_DRAW;
          state_r  <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            case (kind_r)
              K_PART: begin
                part_r  <= div_q[27:0];
                state_r <= S_GEN;
              end
              K_DRAW: begin
                if (div_q < {3'b0, m_r}) begin
                  out_valid_r <= 1'b1;
                  out_value_r <= div_q;
                  state_r     <= S_IDLE;
                end else begin
                  state_r <= S_GEN;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

`ifndef SYNTH
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result without a request in progress");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVW)
    else $error("divider finished outside the wait state");

  a_index_moves_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && idx_r != $past(idx_r)) |->
      ($past(state_r) == S_MIXWR || $past(state_r) == S_WWR1))
    else $error("table index changed outside a table step");

  a_no_go_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVW && !div_done) |=> !div_go_r || $past(div_done))
    else $error("divider restarted while running");
`endif

endmodule

// ===== test/uniform_random_below_bound_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uniform_random_below_bound_checker
// Watches the request, result and register ports of the bounded random
// engine, keeps its own copy of both generators and the registers, works out
// each draw when its request is taken and compares it with the result strobe.
// ----------------------------------------------------------------------------
module uniform_random_below_bound_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_seed,
  input  logic [28:0] in_range_m,
  input  logic        out_valid,
  input  logic [31:0] out_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          results_checked
);
  import urbb_pkg::*;

  localparam logic [31:0] TOP28_MASK = 32'h0FFF_FFFF;
  localparam int          MIX_STEPS  = TABLE_DEPTH * 10;

  logic [31:0] well_words [TABLE_DEPTH];
  logic [4:0]  well_pos;
  logic [31:0] lcg_state;
  logic        sel_lcg;
  logic        fixed_on;
  logic [6:0]  fixed_pct;
  logic [31:0] expected_values [$];
  logic [31:0] oldest;

  function automatic logic [31:0] lcg_advance(input logic [31:0] x);
    return x * LCG_MUL + LCG_ADD;
  endfunction

  function automatic logic [31:0] well_advance();
    logic [4:0]  p_last;
    logic [4:0]  p1;
    logic [4:0]  p2;
    logic [4:0]  p3;
    logic [31:0] t0;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
    logic [31:0] t1;
    logic [31:0] t2;
    p_last = well_pos + 5'd31;
    p1 = well_pos + 5'(WELL_M1);
    p2 = well_pos + 5'(WELL_M2);
    p3 = well_pos + 5'(WELL_M3);
    t0 = well_words[p_last];
    a1 = well_words[p1];
    a2 = well_words[p2];
    a3 = well_words[p3];
    t1 = well_words[well_pos] ^ a1 ^ (a1 >> 8);
    t2 = a2 ^ (a2 << 19) ^ a3 ^ (a3 << 14);
    well_words[well_pos] = t1 ^ t2;
    well_words[p_last] = t0 ^ (t0 << 11) ^ t1 ^ (t1 << 7) ^ t2 ^ (t2 << 13);
    well_pos = p_last;
    return well_words[well_pos];
  endfunction

  function automatic void seed_words(input logic [31:0] s);
    logic [4:0] nxt;
    well_words[0] = s;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      well_words[5'(k)] = lcg_advance(well_words[5'(k - 1)]);
    end
    for (int k = 0; k < MIX_STEPS; k++) begin
      nxt = well_pos + 5'd1;
      well_words[nxt] = well_words[nxt] + well_words[well_pos];
      well_pos = nxt;
    end
  endfunction

  function automatic logic [31:0] draw_below(input logic [28:0] bound);
    logic [28:0] m;
    logic [31:0] part;
    logic [31:0] w;
    logic [31:0] r;
    m = (bound > BOUND_MAX) ? BOUND_MAX : bound;
    if (m <= 29'd1) return 32'd0;
    if (fixed_on) return (32'(fixed_pct) * 32'(FIX_MUL) * (32'(m) - 32'd1)) / FIX_DIV;
    part = 32'(BOUND_MAX) / 32'(m);
    forever begin
      if (sel_lcg) begin
        lcg_state = lcg_advance(lcg_state);
        w = lcg_state;
      end else begin
        w = well_advance();
      end
      r = ((w >> 4) & TOP28_MASK) / part;
      if (r < 32'(m)) return r;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TABLE_DEPTH; k++) well_words[5'(k)] = 32'd0;
      well_pos = 5'd0;
      lcg_state = 32'd0;
      sel_lcg = 1'b1;
      fixed_on = 1'b0;
      fixed_pct = 7'd0;
      expected_values.delete();
    end else begin
      if (out_valid) begin
        if (expected_values.size() == 0) begin
          $error("out_value with no request waiting: actual %h", out_value);
          fail_count++;
        end else begin
          oldest = expected_values.pop_front();
          results_checked++;
          if (out_value !== oldest) begin
            $error("out_value mismatch: expected %h, actual %h", oldest, out_value);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_USE_LCG:   sel_lcg = cfg_wdata[0];
          CFG_FIXED_EN:  fixed_on = cfg_wdata[0];
          CFG_FIXED_PCT: fixed_pct = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_func)
          FUNC_SEED: seed_words(in_seed);
          FUNC_LOAD: lcg_state = in_seed;
          FUNC_DRAW: expected_values.push_back(draw_below(in_range_m));
          default: ;
        endcase
      end
    end
    pending = expected_values.size();
  end

endmodule

// ===== test/tb_uniform_random_below_bound_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uniform_random_below_bound_core
// Drives the bounded random engine with a directed set of bounds, seeds and
// register settings, then with random request streams under several idle
// patterns; the checker beside the block predicts every draw.
// ----------------------------------------------------------------------------
module tb_uniform_random_below_bound_core;
  import urbb_pkg::*;

  localparam logic [1:0] FUNC_NONE     = 2'd3;
  localparam logic [1:0] CFG_NONE      = 2'd3;
  localparam int         SETTLE_CYCLES = 700;
  localparam int         SEGMENTS      = 6;
  localparam int         SEGMENT_ITEMS = 190;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [31:0] in_seed;
  logic [28:0] in_range_m;
  logic        out_valid;
  logic [31:0] out_value;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_wdata;

  int fail_count;
  int pending;
  int results_checked;
  int n_draw;
  int n_seed;
  int n_load;
  int n_ignored;
  int n_settings;

  uniform_random_below_bound_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_seed    (in_seed),
    .in_range_m (in_range_m),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  uniform_random_below_bound_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_seed         (in_seed),
    .in_range_m      (in_range_m),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("uniform_random_below_bound_core verification failed");
    $finish;
  end

  task automatic issue(input logic [1:0] func, input logic [31:0] seed,
                       input logic [28:0] bound);
    start <= 1'b1;
    in_func <= func;
    in_seed <= seed;
    in_range_m <= bound;
    case (func)
      FUNC_DRAW: n_draw++;
      FUNC_SEED: n_seed++;
      FUNC_LOAD: n_load++;
      default:   n_ignored++;
    endcase
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] index, input logic [6:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // upper bits of the one-bit registers are random
  task automatic configure(input logic lcg_sel, input logic fixed_sel,
                           input logic [6:0] pct);
    drain();
    set_reg(CFG_USE_LCG, {6'($urandom), lcg_sel});
    set_reg(CFG_FIXED_EN, {6'($urandom), fixed_sel});
    set_reg(CFG_FIXED_PCT, pct);
    set_reg(CFG_NONE, 7'($urandom));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [28:0] pick_bound();
    case ($urandom_range(0, 9))
      0:       return 29'($urandom_range(0, 1));
      1:       return 29'($urandom_range(2, 16));
      2:       return 29'($urandom_range(17, 1000));
      3:       return BOUND_MAX;
      4:       return BOUND_MAX + 29'($urandom_range(1, 32'h0FFF_FFFF));
      5:       return 29'h0800_0000 + 29'($urandom_range(0, 4096));
      6:       return 29'($urandom);
      default: return 29'($urandom) & 29'h0FFF_FFFF;
    endcase
  endfunction

  function automatic logic [6:0] pick_pct();
    case ($urandom_range(0, 3))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [1:0] pick_func();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return FUNC_SEED;
    if (roll < 10) return FUNC_LOAD;
    if (roll < 13) return FUNC_NONE;
    return FUNC_DRAW;
  endfunction

  initial begin
    int idle_pct;
    int taken;
    logic [1:0] func;
    start <= 1'b0;
    in_func <= FUNC_SEED;
    in_seed <= 32'd0;
    in_range_m <= 29'd0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_USE_LCG;
    cfg_wdata <= 7'd0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // lcg draws, trivial and saturated bounds
    configure(1'b1, 1'b0, 7'd0);
    issue(FUNC_DRAW, 32'd0, 29'd0);
    issue(FUNC_DRAW, 32'hFFFF_FFFF, 29'd1);
    issue(FUNC_DRAW, 32'd0, 29'd2);
    issue(FUNC_DRAW, 32'd0, BOUND_MAX);
    issue(FUNC_DRAW, 32'd0, 29'h1FFF_FFFF);
    issue(FUNC_LOAD, 32'hFFFF_FFFF, 29'd0);
    issue(FUNC_DRAW, 32'd0, 29'h0800_0001);
    issue(FUNC_NONE, 32'hA5A5_A5A5, 29'h1555_5555);
    issue(FUNC_DRAW, 32'd0, 29'd3);

    // well table, first unseeded then seeded
    configure(1'b0, 1'b0, 7'd0);
    issue(FUNC_DRAW, 32'd0, 29'd1000);
    issue(FUNC_SEED, 32'd0, 29'd0);
    issue(FUNC_DRAW, 32'd0, BOUND_MAX);
    issue(FUNC_SEED, 32'hFFFF_FFFF, 29'd0);
    issue(FUNC_DRAW, 32'd0, 29'd7);
    issue(FUNC_DRAW, 32'd0, 29'h0800_0001);
    issue(FUNC_DRAW, 32'd0, 29'h0FFF_FFFF);

    // fixed mode
    configure(1'b0, 1'b1, 7'd100);
    issue(FUNC_DRAW, 32'd0, 29'd0);
    issue(FUNC_DRAW, 32'd0, 29'd1);
    issue(FUNC_DRAW, 32'd0, 29'd2);
    issue(FUNC_DRAW, 32'd0, BOUND_MAX);
    issue(FUNC_DRAW, 32'd0, 29'h1FFF_FFFF);
    issue(FUNC_DRAW, 32'd0, 29'd100001);
    configure(1'b1, 1'b1, 7'd127);
    issue(FUNC_DRAW, 32'd0, BOUND_MAX);
    issue(FUNC_DRAW, 32'd0, 29'd12345);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 0) configure(1'b1, 1'b0, pick_pct());
      else if (seg == 1) configure(1'b0, 1'b0, pick_pct());
      else configure(1'($urandom), $urandom_range(0, 4) == 0, pick_pct());
      idle_pct = (seg < 2) ? 19 : (seg < 4) ? 65 : 0;
      taken = 0;
      while (taken < SEGMENT_ITEMS) begin
        if ($urandom_range(0, 99) < idle_pct) pause($urandom_range(1, 6));
        func = pick_func();
        if (func != FUNC_NONE) taken++;
        issue(func, $urandom, pick_bound());
      end
    end

    drain();
    @(negedge clk);
    $display("covered %0d draws, %0d table seeds, %0d lcg loads, %0d unused commands",
             n_draw, n_seed, n_load, n_ignored);
    $display("over %0d register settings, %0d results compared",
             n_settings, results_checked);
    if (fail_count == 0) begin
      $display("uniform_random_below_bound_core verification clean");
    end else begin
      $display("uniform_random_below_bound_core verification failed");
    end
    $finish;
  end

endmodule
